>>> hw/rtl/bracket_match_completion_scorer_defines.svh
// Assertion macros for the bracket line checker.
`ifndef BRACKET_MATCH_COMPLETION_SCORER_DEFINES_SVH
`define BRACKET_MATCH_COMPLETION_SCORER_DEFINES_SVH

// Same-cycle implication, clocked on aclk and off during reset.
`define BMCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and off during reset.
`define BMCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bmcs_pkg.sv
// Shared types, codes and the bracket decoder for the bracket line checker.
`timescale 1ns / 1ps
package bmcs_pkg;

    localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
    localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
    localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
    localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;
    localparam logic [7:0] CHAR_ANGLE_OPEN   = 8'h3C;
    localparam logic [7:0] CHAR_ANGLE_CLOSE  = 8'h3E;

    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    localparam logic [1:0] STATUS_VALID    = 2'd0;
    localparam logic [1:0] STATUS_CORRUPT  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam int DATA_W_OUT = 88;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic is_bracket;
        logic closing;
        logic [1:0] kind;
    } bracket_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic walk;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last;
        logic walk_done;
        logic out_free;
    } sts_t;

    function automatic bracket_t decode_bracket(input logic [7:0] c);
        bracket_t b;
        b = '{is_bracket: 1'b1, closing: 1'b0, kind: KIND_ROUND};
        unique case (c)
            CHAR_ROUND_OPEN:   b.kind = KIND_ROUND;
            CHAR_SQUARE_OPEN:  b.kind = KIND_SQUARE;
            CHAR_CURLY_OPEN:   b.kind = KIND_CURLY;
            CHAR_ANGLE_OPEN:   b.kind = KIND_ANGLE;
            CHAR_ROUND_CLOSE: begin
                b.closing = 1'b1;
                b.kind    = KIND_ROUND;
            end
            CHAR_SQUARE_CLOSE: begin
                b.closing = 1'b1;
                b.kind    = KIND_SQUARE;
            end
            CHAR_CURLY_CLOSE: begin
                b.closing = 1'b1;
                b.kind    = KIND_CURLY;
            end
            CHAR_ANGLE_CLOSE: begin
                b.closing = 1'b1;
                b.kind    = KIND_ANGLE;
            end
            default: b.is_bracket = 1'b0;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/bmcs_ctrl.sv
// Controller state machine: sequences accept, execute, score walk and emit.
`timescale 1ns / 1ps
module bmcs_ctrl
    import bmcs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    input  sts_t   sts,
    output cmd_t   cmd,
    output logic   in_ready
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = sts.last ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
                if (sts.walk_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_EXEC: cmd.exec = 1'b1;
            ST_WALK: cmd.walk = 1'b1;
            ST_EMIT: cmd.emit = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/bmcs_datapath.sv
// Datapath: bracket stack memory, line flags, score walk and output register.
`timescale 1ns / 1ps
module bmcs_datapath
    import bmcs_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [7:0]            in_char,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_W_OUT-1:0] out_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [1:0] stack_mem [STACK_DEPTH];
    logic [1:0] rdata_reg;
    logic [AW-1:0] raddr;

    logic [7:0]    char_reg;
    logic          last_reg;
    logic [DW-1:0] depth_reg, depth_next;
    logic          corrupt_reg, corrupt_next;
    logic          overflow_reg, overflow_next;
    logic [7:0]    bad_char_reg, bad_char_next;
    logic [DW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;
    logic [63:0]   score_reg, score_next;
    logic          out_valid_reg, out_valid_next;
    logic [DATA_W_OUT-1:0] out_data_reg;

    logic          push_en;
    logic [DW-1:0] depth_dec;
    logic [DW-1:0] idx_dec;
    bracket_t      br;
    logic          active;
    logic          out_free;

    assign br        = decode_bracket(char_reg);
    assign depth_dec = depth_reg - 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign raddr     = cmd.walk ? idx_dec[AW-1:0] : depth_dec[AW-1:0];
    assign active    = !corrupt_reg && !overflow_reg && br.is_bracket;
    assign push_en   = cmd.exec && active && !br.closing && (depth_reg < DW'(STACK_DEPTH));
    assign out_free  = !out_valid_reg || out_ready;

    assign sts.last      = last_reg;
    assign sts.walk_done = (idx_reg == '0) && !pend_reg;
    assign sts.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (push_en) begin
            stack_mem[depth_reg[AW-1:0]] <= br.kind;
        end
        rdata_reg <= stack_mem[raddr];
    end

    always_comb begin
        depth_next    = depth_reg;
        corrupt_next  = corrupt_reg;
        overflow_next = overflow_reg;
        bad_char_next = bad_char_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        score_next    = score_reg;

        if (cmd.exec) begin
            if (active && !br.closing) begin
                if (depth_reg >= DW'(STACK_DEPTH)) begin
                    overflow_next = 1'b1;
                end else begin
                    depth_next = depth_reg + 1'b1;
                end
            end else if (active) begin
                if (depth_reg == '0 || rdata_reg != br.kind) begin
                    corrupt_next  = 1'b1;
                    bad_char_next = char_reg;
                end else begin
                    depth_next = depth_dec;
                end
            end
            // Arm the score walk; a faulted line walks nothing
            if (last_reg) begin
                idx_next   = (corrupt_next || overflow_next) ? '0 : depth_next;
                pend_next  = 1'b0;
                score_next = '0;
            end
        end

        if (cmd.walk) begin
            if (pend_reg) begin
                score_next = {score_reg[61:0], 2'b00} + score_reg
                           + {62'd0, rdata_reg} + 64'd1;
            end
            if (idx_reg != '0) begin
                idx_next  = idx_dec;
                pend_next = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
        end

        // Clear the line state once its result is loaded into the output register
        if (cmd.emit) begin
            depth_next    = '0;
            corrupt_next  = 1'b0;
            overflow_next = 1'b0;
            bad_char_next = '0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            corrupt_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            bad_char_reg  <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            depth_reg     <= depth_next;
            corrupt_reg   <= corrupt_next;
            overflow_reg  <= overflow_next;
            bad_char_reg  <= bad_char_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        score_reg <= score_next;
        if (cmd.accept) begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
        if (cmd.emit) begin
            out_data_reg <= {7'd0,
                             7'(depth_reg),
                             corrupt_reg ? bad_char_reg : 8'd0,
                             score_reg,
                             corrupt_reg  ? STATUS_CORRUPT :
                             overflow_reg ? STATUS_OVERFLOW : STATUS_VALID};
        end
    end

endmodule

>>> hw/rtl/bracket_match_completion_scorer.sv
// Each character is accepted and then updates the bracket stack; a line-end character then
// walks the open brackets of a valid line into its score (one stack read per walk cycle),
// walks nothing for an empty or faulted line, and emits the line result.
// A new character is taken only once the last one is through; a held result stalls input.
// Reset: synchronous, active low; clears the line state and the output valid.
// Stack memory contents are not cleared; only entries written in the line are read.
`timescale 1ns / 1ps
`include "bracket_match_completion_scorer_defines.svh"
module bracket_match_completion_scorer
    import bmcs_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] character
    input  logic                  s_tlast,   // line_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] line_status, [65:2] completion_score, [73:66] offending_char,
    // [80:74] open_depth, [87:81] zero
    output logic [DATA_W_OUT-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    bmcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    bmcs_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    `BMCS_ASSERT_NEXT(a_accept_then_exec, s_tvalid && s_tready, cmd.exec,
        "accepted item not executed")
    `BMCS_ASSERT_NOW(a_fault_no_score, m_tvalid && m_tdata[1:0] != STATUS_VALID,
        m_tdata[65:2] == 64'd0, "faulted line carries a score")
    `BMCS_ASSERT_NOW(a_char_only_corrupt, m_tvalid && m_tdata[1:0] != STATUS_CORRUPT,
        m_tdata[73:66] == 8'd0, "offending char on non-corrupt line")
    `BMCS_ASSERT_NOW(a_emit_only_free, cmd.emit, !m_tvalid || m_tready,
        "result overwrites an untaken item")

endmodule

>>> sim/bracket_match_completion_scorer_tb.sv
// Self-checking testbench: bracket lines in, per-line status and completion score checked.
`timescale 1ns / 1ps
module bracket_match_completion_scorer_tb
    import bmcs_pkg::*;
();

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 920;
    localparam int TAIL_ITEMS   = 200;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] score;
        logic [7:0]  offend;
        logic [6:0]  depth;
    } line_report_t;

    typedef struct packed {
        logic [7:0]   ch;
        logic         last;
        logic         typed;
        line_report_t rep;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DATA_W_OUT-1:0] m_tdata;

    // Predictor state for the line in flight
    logic [1:0]   kind_stack [DEPTH];
    int unsigned  open_cnt;
    bit           line_bad;
    bit           line_over;
    logic [7:0]   bad_char;

    line_report_t pending_lines [$];
    stim_row_t    directed_rows [$];
    line_report_t want;

    int  err_count;
    int  cycles;
    int  chars_sent;
    int  lines_checked;
    int  corrupt_lines;
    int  overflow_lines;
    int  deepest_line;
    bit  tail_phase;
    bit  hold_off_req;

    bracket_match_completion_scorer #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d lines still pending",
                     cycles, pending_lines.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] bracket_char(input logic [1:0] kind, input bit closing);
        case (kind)
            KIND_ROUND:  return closing ? CHAR_ROUND_CLOSE : CHAR_ROUND_OPEN;
            KIND_SQUARE: return closing ? CHAR_SQUARE_CLOSE : CHAR_SQUARE_OPEN;
            KIND_CURLY:  return closing ? CHAR_CURLY_CLOSE : CHAR_CURLY_OPEN;
            default:     return closing ? CHAR_ANGLE_CLOSE : CHAR_ANGLE_OPEN;
        endcase
    endfunction

    // Advance the line state by one character; return 1 with the line report on line end.
    function automatic bit track_bracket(input logic [7:0] ch, input bit last,
                                         output line_report_t rep);
        int         k;
        bit         hit;
        bit         closing;
        logic [1:0] kind;
        hit     = 1'b0;
        closing = 1'b0;
        kind    = KIND_ROUND;
        for (k = 0; k < 4; k++) begin
            if (ch == bracket_char(k[1:0], 1'b0)) begin
                hit  = 1'b1;
                kind = k[1:0];
            end
            if (ch == bracket_char(k[1:0], 1'b1)) begin
                hit     = 1'b1;
                closing = 1'b1;
                kind    = k[1:0];
            end
        end
        // only the first fault of a line counts
        if (hit && !line_bad && !line_over) begin
            if (!closing) begin
                if (open_cnt >= DEPTH) begin
                    line_over = 1'b1;
                end else begin
                    kind_stack[open_cnt] = kind;
                    open_cnt++;
                end
            end else if (open_cnt == 0 || kind_stack[open_cnt-1] != kind) begin
                line_bad = 1'b1;
                bad_char = ch;
            end else begin
                open_cnt--;
            end
        end
        rep = '0;
        if (!last) return 1'b0;
        if (line_bad) begin
            rep.status = STATUS_CORRUPT;
            rep.offend = bad_char;
            corrupt_lines++;
        end else if (line_over) begin
            rep.status = STATUS_OVERFLOW;
            overflow_lines++;
        end else begin
            rep.status = STATUS_VALID;
            for (k = int'(open_cnt) - 1; k >= 0; k--)
                rep.score = rep.score * 64'd5 + kind_stack[k] + 64'd1;
        end
        rep.depth = open_cnt[6:0];
        if (open_cnt > deepest_line) deepest_line = open_cnt;
        open_cnt  = 0;
        line_bad  = 1'b0;
        line_over = 1'b0;
        bad_char  = 8'h00;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= 40) $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task automatic add_row(input logic [7:0] ch, input logic last);
        stim_row_t row;
        row = '{ch: ch, last: last, typed: 1'b0, rep: '0};
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_checked_end(input logic [7:0] ch, input logic [1:0] status,
                                   input logic [63:0] score, input logic [7:0] offend,
                                   input logic [6:0] depth);
        stim_row_t row;
        row = '{ch: ch, last: 1'b1, typed: 1'b1,
                rep: '{status: status, score: score, offend: offend, depth: depth}};
        directed_rows = {directed_rows, row};
    endtask

    // Offer one item, with an occasional idle burst ahead of it, and log it once taken.
    task automatic send_item(input logic [7:0] ch, input bit last, input bit typed,
                             input line_report_t typed_rep);
        line_report_t rep;
        if (!tail_phase && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        if (track_bracket(ch, last, rep)) begin
            if (typed) rep = typed_rep;
            pending_lines = {pending_lines, rep};
        end
    endtask

    // Result side: random stalls, one long hold-off on request, none in the tail.
    initial begin
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!tail_phase && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(30, 60)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lines.size() == 0) begin
                flag_mismatch("line result with no line pending");
            end else begin
                want = pending_lines.pop_front();
                lines_checked++;
                if (m_tdata[1:0] !== want.status)
                    flag_mismatch($sformatf("line %0d status got %0d want %0d",
                                            lines_checked, m_tdata[1:0], want.status));
                if (m_tdata[65:2] !== want.score)
                    flag_mismatch($sformatf("line %0d score got %0h want %0h",
                                            lines_checked, m_tdata[65:2], want.score));
                if (m_tdata[73:66] !== want.offend)
                    flag_mismatch($sformatf("line %0d offending char got %0h want %0h",
                                            lines_checked, m_tdata[73:66], want.offend));
                if (m_tdata[80:74] !== want.depth)
                    flag_mismatch($sformatf("line %0d open depth got %0d want %0d",
                                            lines_checked, m_tdata[80:74], want.depth));
                if (m_tdata[87:81] !== 7'd0)
                    flag_mismatch($sformatf("line %0d pad bits got %0h",
                                            lines_checked, m_tdata[87:81]));
            end
        end
    end

    initial begin
        int           i;
        int           mode;
        int           len;
        int           sp;
        int           r;
        int           random_start;
        logic [1:0]   k;
        logic [1:0]   gen_stack [128];
        logic [7:0]   line_q [$];
        logic [7:0]   ch;
        line_report_t none;

        none           = '0;
        err_count      = 0;
        cycles         = 0;
        chars_sent     = 0;
        lines_checked  = 0;
        corrupt_lines  = 0;
        overflow_lines = 0;
        deepest_line   = 0;
        tail_phase     = 1'b0;
        hold_off_req   = 1'b0;
        open_cnt       = 0;
        line_bad       = 1'b0;
        line_over      = 1'b0;
        bad_char       = 8'h00;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mismatched close with one open
        add_row(CHAR_ROUND_OPEN, 1'b0);
        add_checked_end(CHAR_SQUARE_CLOSE, STATUS_CORRUPT, 64'd0, CHAR_SQUARE_CLOSE, 7'd1);
        // close on an empty stack
        add_checked_end(CHAR_ROUND_CLOSE, STATUS_CORRUPT, 64'd0, CHAR_ROUND_CLOSE, 7'd0);
        add_checked_end(CHAR_ANGLE_OPEN, STATUS_VALID, 64'd4, 8'h00, 7'd1);
        add_row(CHAR_CURLY_OPEN, 1'b0);
        add_checked_end(CHAR_SQUARE_OPEN, STATUS_VALID, 64'd13, 8'h00, 7'd2);
        // balanced line with byte extremes as filler
        add_row(CHAR_SQUARE_OPEN, 1'b0);
        add_row(8'hFF, 1'b0);
        add_row(CHAR_SQUARE_CLOSE, 1'b0);
        add_checked_end(8'h00, STATUS_VALID, 64'd0, 8'h00, 7'd0);
        // first fault wins, the rest of the line is ignored
        add_row(CHAR_ROUND_OPEN, 1'b0);
        add_row(CHAR_ANGLE_OPEN, 1'b0);
        add_row(CHAR_ANGLE_CLOSE, 1'b0);
        add_row(CHAR_CURLY_CLOSE, 1'b0);
        add_row(CHAR_ROUND_CLOSE, 1'b0);
        add_checked_end(CHAR_ANGLE_OPEN, STATUS_CORRUPT, 64'd0, CHAR_CURLY_CLOSE, 7'd1);
        add_row(CHAR_CURLY_OPEN, 1'b0);
        add_row(CHAR_CURLY_CLOSE, 1'b0);
        add_checked_end(CHAR_ANGLE_CLOSE, STATUS_CORRUPT, 64'd0, CHAR_ANGLE_CLOSE, 7'd0);
        add_checked_end(8'hFF, STATUS_VALID, 64'd0, 8'h00, 7'd0);
        // all four kinds open
        add_row(CHAR_ROUND_OPEN, 1'b0);
        add_row(CHAR_SQUARE_OPEN, 1'b0);
        add_row(CHAR_CURLY_OPEN, 1'b0);
        add_row(CHAR_ANGLE_OPEN, 1'b0);
        add_row(8'h80, 1'b1);

        foreach (directed_rows[j])
            send_item(directed_rows[j].ch, directed_rows[j].last,
                      directed_rows[j].typed, directed_rows[j].rep);

        // full stack of angles: largest digits, score wraps
        for (i = 0; i < DEPTH; i++)
            send_item(CHAR_ANGLE_OPEN, i == DEPTH - 1, 1'b0, none);
        // full stack of mixed kinds
        for (i = 0; i < DEPTH; i++)
            send_item(bracket_char(2'($urandom_range(0, 3)), 1'b0), i == DEPTH - 1,
                      1'b0, none);
        // push past full, then a close that must be ignored
        for (i = 0; i <= DEPTH; i++)
            send_item(CHAR_ROUND_OPEN, 1'b0, 1'b0, none);
        send_item(CHAR_ROUND_CLOSE, 1'b1, 1'b0, none);
        // overflow on the line-end character itself
        for (i = 0; i <= DEPTH; i++)
            send_item(CHAR_SQUARE_OPEN, i == DEPTH, 1'b0, none);

        // random lines: mostly well nested, some with a wrong close, some raw noise
        hold_off_req = 1'b1;
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_ITEMS) begin
            if (chars_sent - random_start >= RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
            mode = $urandom_range(0, 99);
            len  = ($urandom_range(0, 14) == 0) ? $urandom_range(40, 72)
                                                : $urandom_range(1, 14);
            sp   = 0;
            line_q.delete();
            for (i = 0; i < len; i++) begin
                r = $urandom_range(0, 9);
                if (mode < 10 || r < 2) begin
                    ch = 8'($urandom_range(0, 255));
                end else if (r < ((len >= 40) ? 8 : 6) || sp == 0) begin
                    k = 2'($urandom_range(0, 3));
                    gen_stack[sp] = k;
                    sp++;
                    ch = bracket_char(k, 1'b0);
                end else if (mode < 30 && $urandom_range(0, 5) == 0) begin
                    k  = gen_stack[sp-1] ^ 2'($urandom_range(1, 3));
                    ch = bracket_char(k, 1'b1);
                end else begin
                    sp--;
                    ch = bracket_char(gen_stack[sp], 1'b1);
                end
                line_q = {line_q, ch};
            end
            foreach (line_q[j])
                send_item(line_q[j], j == line_q.size() - 1, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_lines.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d lines over %0d characters: %0d corrupt, %0d overflowed,",
                 lines_checked, chars_sent, corrupt_lines, overflow_lines);
        $display("deepest open stack %0d, with one long result-side hold-off", deepest_line);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bmcs_pkg.sv
hw/rtl/bmcs_ctrl.sv
hw/rtl/bmcs_datapath.sv
hw/rtl/bracket_match_completion_scorer.sv
sim/bracket_match_completion_scorer_tb.sv
